// ===== rtl/core/trwb_pkg.sv =====
package trwb_pkg;

	localparam int SCREEN_WIDTH  = 256;
	localparam int SCREEN_HEIGHT = 256;
	localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;

	localparam int X_W    = $clog2(SCREEN_WIDTH);
	localparam int Y_W    = $clog2(SCREEN_HEIGHT);
	localparam int YC_W   = $clog2(SCREEN_HEIGHT + 1);
	localparam int ADDR_W = $clog2(PIXEL_COUNT);

	localparam int CMD_W   = 2;
	localparam int COORD_W = 16;
	localparam int DEPTH_W = 32;
	localparam int COLOR_W = 24;

	// Interpolated x, row distances and divisor widths.
	localparam int XS_W   = 17;
	localparam int D_W    = 17;
	localparam int DEN_W  = 17;
	localparam int NUM_W  = 50;
	localparam int MA_W   = 33;
	localparam int MB_W   = 18;
	localparam int PROD_W = MA_W + MB_W;
	localparam int ACC_W  = 52;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [NUM_W-1:0]  quot;
		logic [DEN_W-1:0]  rem;
	} div_st_t;

	function automatic logic [ADDR_W-1:0] pix_addr(input logic [Y_W-1:0] y,
		input logic [X_W-1:0] x);
		pix_addr = ADDR_W'(ADDR_W'(y) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(x));
	endfunction

endpackage

// ===== rtl/core/trwb_div.sv =====
module trwb_div import trwb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_st_t  st
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	// Restoring division, one quotient bit per cycle shifted into num_q.
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
				num_q  <= req.num;
				den_q  <= req.den;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
				num_q <= {num_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign st.done = done_q;
	assign st.quot = num_q;
	assign st.rem  = rem_q;

endmodule

// ===== rtl/core/trapezoid_rasterizer_wbuffer_core.sv =====
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   command, corner x, w and rows, fill_color
// out       output     out_valid / out_stall drawn, pixel_color, pixel_depth
// cfg       input      cfg_valid / cfg_ready background_color
//
// Draw: per screen row, edge interpolation of left and right x and w on one shared serial
// divider, then span setup of start w and w step, then one pixel per cycle through the
// single read port of the depth memory. Clear: one entry per cycle. Read: a registered
// memory read. One item is worked at a time; the result register frees the input side.
// Reset clears control and bg_q only; memory contents are undefined until the first clear.
// A stalled result holds the block in its final step until the transaction completes.
module trapezoid_rasterizer_wbuffer_core import trwb_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [CMD_W-1:0]           command,
	input  logic signed [COORD_W-1:0]  top_left_x,
	input  logic [DEPTH_W-1:0]         top_left_w,
	input  logic signed [COORD_W-1:0]  top_right_x,
	input  logic [DEPTH_W-1:0]         top_right_w,
	input  logic signed [COORD_W-1:0]  top_row,
	input  logic signed [COORD_W-1:0]  bottom_left_x,
	input  logic [DEPTH_W-1:0]         bottom_left_w,
	input  logic signed [COORD_W-1:0]  bottom_right_x,
	input  logic [DEPTH_W-1:0]         bottom_right_w,
	input  logic signed [COORD_W-1:0]  bottom_row,
	input  logic [COLOR_W-1:0]         fill_color,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       drawn,
	output logic [COLOR_W-1:0]         pixel_color,
	output logic [DEPTH_W-1:0]         pixel_depth,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [COLOR_W-1:0]         background_color
);

	localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic signed [XS_W-1:0] SW_S = XS_W'(SCREEN_WIDTH);
	localparam logic signed [XS_W-1:0] SH_S = XS_W'(SCREEN_HEIGHT);

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_RD_WAIT, S_ROW, S_MUL1, S_MUL2, S_SUM, S_DIV,
		S_DIV_WAIT, S_SPAN, S_DELTA, S_PIX, S_ROW_NEXT, S_FINISH
	} state_t;

	typedef enum logic [2:0] {
		PH_XL, PH_XR, PH_WL, PH_WR, PH_SPAN0, PH_DELTA
	} phase_t;

	state_t state_q;
	phase_t phase_q;

	logic signed [COORD_W-1:0] tlx_q, trx_q, blx_q, brx_q;
	logic [DEPTH_W-1:0]        tlw_q, trw_q, blw_q, brw_q;
	logic [COLOR_W-1:0]        color_q, bg_q;
	logic [D_W-1:0]            d_q, k_q;
	logic [YC_W-1:0]           y_q, y_end_q;
	logic signed [XS_W-1:0]    xl_q, xr_q;
	logic [DEPTH_W-1:0]        wl_q, wr_q;
	logic [X_W-1:0]            lo_q, i_q, hi_q;
	logic [DEN_W-1:0]          len_q, den_q;
	logic                      neg_q;
	logic [DEPTH_W-1:0]        wcur_q, qd_q;
	logic [DEN_W-1:0]          rcur_q, rd_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [ADDR_W-1:0]         clr_q;

	logic                      res_drawn_q;
	logic [COLOR_W-1:0]        res_color_q;
	logic [DEPTH_W-1:0]        res_depth_q;
	logic                      out_valid_q;
	logic                      drawn_q;
	logic [COLOR_W-1:0]        pixel_color_q;
	logic [DEPTH_W-1:0]        pixel_depth_q;

	logic                      pv_s1;
	logic [ADDR_W-1:0]         paddr_s1;
	logic [DEPTH_W-1:0]        pw_s1;

	logic [COLOR_W-1:0]        color_mem [PIXEL_COUNT];
	logic [DEPTH_W-1:0]        depth_mem [PIXEL_COUNT];
	logic [COLOR_W-1:0]        rd_color_q;
	logic [DEPTH_W-1:0]        rd_depth_q;

	div_req_t div_req;
	div_st_t  div_st;

	// Input decode.
	logic signed [XS_W-1:0] ty_e, by_e, tlx_e, y0, y1, k0, d0;
	logic                   draw_off, rd_inside;

	always_comb begin
		ty_e      = {top_row[COORD_W-1], top_row};
		by_e      = {bottom_row[COORD_W-1], bottom_row};
		tlx_e     = {top_left_x[COORD_W-1], top_left_x};
		draw_off  = (by_e < 0) || (ty_e >= SH_S);
		y0        = (ty_e < 0) ? '0 : ty_e;
		y1        = (by_e > SH_S) ? SH_S : by_e;
		k0        = y0 - ty_e;
		d0        = by_e - ty_e;
		rd_inside = (tlx_e >= 0) && (tlx_e < SW_S) && (ty_e >= 0) && (ty_e < SH_S);
	end

	// Shared multiplier operands.
	logic signed [XS_W-1:0]   dxl, dxr, lo_e, b_hi, b_lo;
	logic signed [MA_W-1:0]   a1, a2, mul_a;
	logic signed [MB_W-1:0]   b1, b2, mul_b;
	logic signed [PROD_W-1:0] product;
	logic                     xphase;

	always_comb begin
		dxl  = {blx_q[COORD_W-1], blx_q} - {tlx_q[COORD_W-1], tlx_q};
		dxr  = {brx_q[COORD_W-1], brx_q} - {trx_q[COORD_W-1], trx_q};
		lo_e = {{(XS_W-X_W){1'b0}}, lo_q};
		b_hi = xr_q - lo_e;
		b_lo = lo_e - xl_q;
		a1 = '0;
		b1 = '0;
		a2 = '0;
		b2 = '0;
		case (phase_q)
			PH_XL: begin
				a1 = {{(MA_W-COORD_W){tlx_q[COORD_W-1]}}, tlx_q};
				b1 = {1'b0, d_q};
				a2 = {{(MA_W-XS_W){dxl[XS_W-1]}}, dxl};
				b2 = {1'b0, k_q};
			end
			PH_XR: begin
				a1 = {{(MA_W-COORD_W){trx_q[COORD_W-1]}}, trx_q};
				b1 = {1'b0, d_q};
				a2 = {{(MA_W-XS_W){dxr[XS_W-1]}}, dxr};
				b2 = {1'b0, k_q};
			end
			PH_WL: begin
				a1 = {1'b0, tlw_q};
				b1 = {1'b0, d_q - k_q};
				a2 = {1'b0, blw_q};
				b2 = {1'b0, k_q};
			end
			PH_WR: begin
				a1 = {1'b0, trw_q};
				b1 = {1'b0, d_q - k_q};
				a2 = {1'b0, brw_q};
				b2 = {1'b0, k_q};
			end
			PH_SPAN0: begin
				a1 = {1'b0, wl_q};
				b1 = {1'b0, b_hi};
				a2 = {1'b0, wr_q};
				b2 = {1'b0, b_lo};
			end
			default: begin
				a1 = '0;
			end
		endcase
		mul_a   = (state_q == S_MUL2) ? a2 : a1;
		mul_b   = (state_q == S_MUL2) ? b2 : b1;
		product = mul_a * mul_b;
		xphase  = (phase_q == PH_XL) || (phase_q == PH_XR);
	end

	// Accumulator terms. Edge x uses 2 * (sum) + D over 2 * D for round half up.
	logic signed [ACC_W-1:0] prod_ext, prod_sh, dterm, acc_mag;
	logic [DEN_W-1:0]        den_sel;

	always_comb begin
		prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
		prod_sh  = xphase ? {prod_ext[ACC_W-2:0], 1'b0} : prod_ext;
		dterm    = xphase ? {{(ACC_W-D_W){1'b0}}, d_q} : '0;
		acc_mag  = acc_q[ACC_W-1] ? -acc_q : acc_q;
		case (phase_q)
			PH_XL, PH_XR: den_sel = {d_q[D_W-2:0], 1'b0};
			PH_WL, PH_WR: den_sel = d_q;
			default:      den_sel = len_q;
		endcase
		div_req.start = (state_q == S_DIV);
		div_req.num   = acc_mag[NUM_W-1:0];
		div_req.den   = den_sel;
	end

	// Floor quotient and non-negative remainder from the unsigned divider.
	logic [NUM_W-1:0] q_s;
	logic [DEN_W-1:0] r_s;
	logic             rem_nz;

	always_comb begin
		rem_nz = div_st.rem != '0;
		if (neg_q && rem_nz) begin
			q_s = ~div_st.quot;
			r_s = den_q - div_st.rem;
		end else if (neg_q) begin
			q_s = -div_st.quot;
			r_s = div_st.rem;
		end else begin
			q_s = div_st.quot;
			r_s = div_st.rem;
		end
	end

	// Span clipping.
	logic                   span_skip;
	logic [X_W-1:0]         span_lo, span_hi;
	logic signed [XS_W-1:0] span_len;

	always_comb begin
		span_skip = (xl_q > xr_q) || (xr_q < 0) || (xl_q >= SW_S);
		span_lo   = (xl_q < 0) ? '0 : xl_q[X_W-1:0];
		span_hi   = (xr_q > SW_S - XS_W'(1)) ? X_W'(SCREEN_WIDTH - 1) : xr_q[X_W-1:0];
		span_len  = xr_q - xl_q;
	end

	// Incremental w along the span: quotient and remainder stepped by delta / len.
	logic [DEN_W:0] rsum;
	logic           rwrap;

	always_comb begin
		rsum  = {1'b0, rcur_q} + {1'b0, rd_q};
		rwrap = rsum >= {1'b0, len_q};
	end

	// Memory port control.
	logic              rd_en, wr_en, accept;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [COLOR_W-1:0] wr_color;
	logic [DEPTH_W-1:0] wr_depth;

	always_comb begin
		accept  = in_valid && (state_q == S_IDLE);
		rd_en   = 1'b0;
		rd_addr = pix_addr(y_q[Y_W-1:0], i_q);
		if (state_q == S_PIX) begin
			rd_en = 1'b1;
		end else if (accept && command == CMD_READ && rd_inside) begin
			rd_en   = 1'b1;
			rd_addr = pix_addr(top_row[Y_W-1:0], top_left_x[X_W-1:0]);
		end
		if (state_q == S_CLEAR) begin
			wr_en    = 1'b1;
			wr_addr  = clr_q;
			wr_color = bg_q;
			wr_depth = '0;
		end else begin
			wr_en    = pv_s1 && (rd_depth_q < pw_s1);
			wr_addr  = paddr_s1;
			wr_color = color_q;
			wr_depth = pw_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			color_mem[wr_addr] <= wr_color;
		end
		if (rd_en) begin
			rd_color_q <= color_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			depth_mem[wr_addr] <= wr_depth;
		end
		if (rd_en) begin
			rd_depth_q <= depth_mem[rd_addr];
		end
	end

	trwb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.st     (div_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_XL;
			out_valid_q <= 1'b0;
			pv_s1       <= 1'b0;
			bg_q        <= '0;
		end else begin
			if (cfg_valid) begin
				bg_q <= background_color;
			end
			if (state_q == S_FINISH && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			pv_s1 <= (state_q == S_PIX);
			if (state_q == S_MUL1 || state_q == S_MUL2) begin
				prod_q <= product;
			end
			case (state_q)
				S_IDLE: begin
					res_drawn_q <= 1'b0;
					res_color_q <= '0;
					res_depth_q <= '0;
					if (accept) begin
						tlx_q   <= top_left_x;
						trx_q   <= top_right_x;
						blx_q   <= bottom_left_x;
						brx_q   <= bottom_right_x;
						tlw_q   <= top_left_w;
						trw_q   <= top_right_w;
						blw_q   <= bottom_left_w;
						brw_q   <= bottom_right_w;
						color_q <= fill_color;
						y_q     <= y0[YC_W-1:0];
						y_end_q <= y1[YC_W-1:0];
						k_q     <= k0[D_W-1:0];
						d_q     <= d0[D_W-1:0];
						clr_q   <= '0;
						case (command)
							CMD_DRAW:  state_q <= draw_off ? S_FINISH : S_ROW;
							CMD_CLEAR: state_q <= S_CLEAR;
							CMD_READ:  state_q <= rd_inside ? S_RD_WAIT : S_FINISH;
							default:   state_q <= S_FINISH;
						endcase
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(PIXEL_COUNT - 1)) begin
						state_q <= S_FINISH;
					end
				end
				S_RD_WAIT: begin
					res_color_q <= rd_color_q;
					res_depth_q <= rd_depth_q;
					state_q     <= S_FINISH;
				end
				S_ROW: begin
					if (y_q >= y_end_q) begin
						res_drawn_q <= 1'b1;
						state_q     <= S_FINISH;
					end else begin
						phase_q <= PH_XL;
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					acc_q   <= prod_sh + dterm;
					state_q <= S_SUM;
				end
				S_SUM: begin
					acc_q   <= acc_q + prod_sh;
					state_q <= S_DIV;
				end
				S_DIV: begin
					neg_q   <= acc_q[ACC_W-1];
					den_q   <= den_sel;
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_st.done) begin
						case (phase_q)
							PH_XL: begin
								xl_q    <= q_s[XS_W-1:0];
								phase_q <= PH_XR;
								state_q <= S_MUL1;
							end
							PH_XR: begin
								xr_q    <= q_s[XS_W-1:0];
								phase_q <= PH_WL;
								state_q <= S_MUL1;
							end
							PH_WL: begin
								wl_q    <= q_s[DEPTH_W-1:0];
								phase_q <= PH_WR;
								state_q <= S_MUL1;
							end
							PH_WR: begin
								wr_q    <= q_s[DEPTH_W-1:0];
								state_q <= S_SPAN;
							end
							PH_SPAN0: begin
								wcur_q  <= q_s[DEPTH_W-1:0];
								rcur_q  <= r_s;
								phase_q <= PH_DELTA;
								state_q <= S_DELTA;
							end
							default: begin
								qd_q    <= q_s[DEPTH_W-1:0];
								rd_q    <= r_s;
								state_q <= S_PIX;
							end
						endcase
					end
				end
				S_SPAN: begin
					lo_q  <= span_lo;
					i_q   <= span_lo;
					hi_q  <= span_hi;
					len_q <= span_len[DEN_W-1:0];
					if (span_skip) begin
						state_q <= S_ROW_NEXT;
					end else if (span_len == 0) begin
						// A single-pixel span takes the right edge w as it is.
						wcur_q  <= wr_q;
						rcur_q  <= '0;
						qd_q    <= '0;
						rd_q    <= '0;
						state_q <= S_PIX;
					end else begin
						phase_q <= PH_SPAN0;
						state_q <= S_MUL1;
					end
				end
				S_DELTA: begin
					acc_q   <= {{(ACC_W-DEPTH_W){1'b0}}, wr_q} -
						{{(ACC_W-DEPTH_W){1'b0}}, wl_q};
					state_q <= S_DIV;
				end
				S_PIX: begin
					paddr_s1 <= rd_addr;
					pw_s1    <= wcur_q;
					rcur_q   <= rwrap ? DEN_W'(rsum - {1'b0, len_q}) : rsum[DEN_W-1:0];
					wcur_q   <= wcur_q + qd_q + DEPTH_W'(rwrap);
					if (i_q == hi_q) begin
						state_q <= S_ROW_NEXT;
					end else begin
						i_q <= i_q + X_W'(1);
					end
				end
				S_ROW_NEXT: begin
					y_q     <= y_q + YC_W'(1);
					k_q     <= k_q + D_W'(1);
					state_q <= S_ROW;
				end
				S_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						drawn_q       <= res_drawn_q;
						pixel_color_q <= res_color_q;
						pixel_depth_q <= res_depth_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = state_q != S_IDLE;
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign drawn       = drawn_q;
	assign pixel_color = pixel_color_q;
	assign pixel_depth = pixel_depth_q;

`ifndef SYNTHESIS
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == S_DIV_WAIT)
		else $error("divider finished outside its wait step");

	a_pix_not_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pv_s1 |-> state_q != S_CLEAR)
		else $error("pixel write overlaps the clear sweep");

	a_pix_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PIX |-> i_q <= hi_q)
		else $error("pixel index ran past the span end");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && out_valid_q && out_stall) |=> state_q == S_FINISH)
		else $error("result dropped while the output register was full");
`endif

endmodule

// ===== test/trapezoid_rasterizer_wbuffer_core_tb.sv =====
`timescale 1ns / 1ps

module trapezoid_rasterizer_wbuffer_core_tb;
	import trwb_pkg::*;

	typedef longint unsigned u64_t;

	localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic [CMD_W-1:0]          cmd;
		logic signed [COORD_W-1:0] tlx, trx, ty, blx, brx, by;
		logic [DEPTH_W-1:0]        tlw, trw, blw, brw;
		logic [COLOR_W-1:0]        color;
	} raster_cmd_t;

	typedef struct {
		logic               drawn;
		logic [COLOR_W-1:0] color;
		logic [DEPTH_W-1:0] depth;
	} pixel_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [CMD_W-1:0]          command;
	logic signed [COORD_W-1:0] top_left_x, top_right_x, top_row;
	logic signed [COORD_W-1:0] bottom_left_x, bottom_right_x, bottom_row;
	logic [DEPTH_W-1:0]        top_left_w, top_right_w, bottom_left_w, bottom_right_w;
	logic [COLOR_W-1:0]        fill_color;
	logic                      out_valid;
	logic                      out_stall;
	logic                      drawn;
	logic [COLOR_W-1:0]        pixel_color;
	logic [DEPTH_W-1:0]        pixel_depth;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [COLOR_W-1:0]        background_color;

	// Shadow copy of the frame buffer, w-buffer and background register.
	logic [COLOR_W-1:0] frame_shadow [PIXEL_COUNT];
	logic [DEPTH_W-1:0] wbuf_shadow [PIXEL_COUNT];
	logic [COLOR_W-1:0] bg_shadow;
	pixel_result_t      pending_results [$];
	int                 error_count;
	bit                 quiet_phase;
	int                 stall_left;

	trapezoid_rasterizer_wbuffer_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .command(command),
		.top_left_x(top_left_x), .top_left_w(top_left_w),
		.top_right_x(top_right_x), .top_right_w(top_right_w), .top_row(top_row),
		.bottom_left_x(bottom_left_x), .bottom_left_w(bottom_left_w),
		.bottom_right_x(bottom_right_x), .bottom_right_w(bottom_right_w),
		.bottom_row(bottom_row), .fill_color(fill_color),
		.out_valid(out_valid), .out_stall(out_stall), .drawn(drawn),
		.pixel_color(pixel_color), .pixel_depth(pixel_depth),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .background_color(background_color)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int rnd(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic int gap_len();
		int r;
		r = rnd(0, 99);
		if (quiet_phase || r < 45)
			return 0;
		if (r < 85)
			return rnd(1, 3);
		if (r < 97)
			return rnd(4, 12);
		return rnd(20, 60);
	endfunction

	function automatic longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic void shade_span(longint xl, logic [31:0] wl, longint xr,
		logic [31:0] wr, longint y, logic [COLOR_W-1:0] color);
		longint lo, hi, i, len;
		logic [31:0] w;
		int idx;
		if (xl > xr || xr < 0 || xl >= SCREEN_WIDTH)
			return;
		lo = (xl < 0) ? 0 : xl;
		hi = (xr > SCREEN_WIDTH - 1) ? SCREEN_WIDTH - 1 : xr;
		len = xr - xl;
		for (i = lo; i <= hi; i++) begin
			idx = int'(y * SCREEN_WIDTH + i);
			if (len == 0)
				w = wr;
			else
				w = 32'((u64_t'(wl) * u64_t'(xr - i) + u64_t'(wr) * u64_t'(i - xl))
					/ u64_t'(len));
			if (wbuf_shadow[idx] < w) begin
				wbuf_shadow[idx] = w;
				frame_shadow[idx] = color;
			end
		end
	endfunction

	function automatic logic rasterize_trapezoid(raster_cmd_t c);
		longint tlx, trx, ty, blx, brx, by, d, y, y0, y1, k, xl, xr;
		logic [31:0] wl, wr;
		tlx = longint'(c.tlx); trx = longint'(c.trx); ty = longint'(c.ty);
		blx = longint'(c.blx); brx = longint'(c.brx); by = longint'(c.by);
		if (by < 0 || ty >= SCREEN_HEIGHT)
			return 1'b0;
		d = by - ty;
		y0 = (ty < 0) ? 0 : ty;
		y1 = (by > SCREEN_HEIGHT) ? SCREEN_HEIGHT : by;
		for (y = y0; y < y1; y++) begin
			k = y - ty;
			xl = floor_div(2 * (tlx * d + (blx - tlx) * k) + d, 2 * d);
			xr = floor_div(2 * (trx * d + (brx - trx) * k) + d, 2 * d);
			wl = 32'((u64_t'(c.tlw) * u64_t'(d - k) + u64_t'(c.blw) * u64_t'(k)) / u64_t'(d));
			wr = 32'((u64_t'(c.trw) * u64_t'(d - k) + u64_t'(c.brw) * u64_t'(k)) / u64_t'(d));
			shade_span(xl, wl, xr, wr, y, c.color);
		end
		return 1'b1;
	endfunction

	function automatic pixel_result_t predict_result(raster_cmd_t c);
		pixel_result_t r;
		longint x, y;
		int idx;
		r = '{1'b0, '0, '0};
		case (c.cmd)
			CMD_DRAW: begin
				r.drawn = rasterize_trapezoid(c);
			end
			CMD_CLEAR: begin
				for (idx = 0; idx < PIXEL_COUNT; idx++) begin
					frame_shadow[idx] = bg_shadow;
					wbuf_shadow[idx] = '0;
				end
			end
			CMD_READ: begin
				x = longint'(c.tlx);
				y = longint'(c.ty);
				if (x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT) begin
					idx = int'(y * SCREEN_WIDTH + x);
					r.color = frame_shadow[idx];
					r.depth = wbuf_shadow[idx];
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic send_command(raster_cmd_t c);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c.cmd;
		top_left_x <= c.tlx;
		top_left_w <= c.tlw;
		top_right_x <= c.trx;
		top_right_w <= c.trw;
		top_row <= c.ty;
		bottom_left_x <= c.blx;
		bottom_left_w <= c.blw;
		bottom_right_x <= c.brx;
		bottom_right_w <= c.brw;
		bottom_row <= c.by;
		fill_color <= c.color;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.insert(pending_results.size(), predict_result(c));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_background(logic [COLOR_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		background_color <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		bg_shadow = value;
	endtask

	function automatic raster_cmd_t make_cmd(logic [CMD_W-1:0] cmd, int tlx, int trx,
		int ty, int blx, int brx, int by, logic [31:0] tlw, logic [31:0] trw,
		logic [31:0] blw, logic [31:0] brw, logic [COLOR_W-1:0] color);
		raster_cmd_t c;
		c.cmd = cmd;
		c.tlx = COORD_W'(tlx); c.trx = COORD_W'(trx); c.ty = COORD_W'(ty);
		c.blx = COORD_W'(blx); c.brx = COORD_W'(brx); c.by = COORD_W'(by);
		c.tlw = tlw; c.trw = trw; c.blw = blw; c.brw = brw;
		c.color = color;
		return c;
	endfunction

	function automatic raster_cmd_t make_read(int x, int y);
		return make_cmd(CMD_READ, x, $urandom, y, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, COLOR_W'($urandom));
	endfunction

	function automatic raster_cmd_t random_draw();
		raster_cmd_t c;
		int h, ty;
		h = (rnd(0, 9) == 0) ? rnd(13, 60) : rnd(1, 10);
		ty = rnd(-15, 262);
		c = make_cmd(CMD_DRAW, 0, 0, ty, 0, 0, ty + h, $urandom, $urandom, $urandom,
			$urandom, COLOR_W'($urandom));
		c.tlx = COORD_W'(rnd(-30, 270));
		c.trx = COORD_W'(int'(c.tlx) + rnd(0, (rnd(0, 4) == 0) ? 200 : 30));
		c.blx = COORD_W'(rnd(-30, 270));
		c.brx = COORD_W'(int'(c.blx) + rnd(0, 30));
		// Some noise: arbitrary x, crossed edges included.
		if (rnd(0, 6) == 0) begin
			c.tlx = COORD_W'($urandom);
			c.trx = COORD_W'($urandom);
			c.blx = COORD_W'($urandom);
			c.brx = COORD_W'($urandom);
		end
		return c;
	endfunction

	task automatic test_clear_and_read();
		write_background(24'h000000);
		send_command(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_command(make_read(0, 0));
		send_command(make_read(255, 255));
		send_command(make_read(-1, 0));
		send_command(make_read(256, 5));
		send_command(make_read(-32768, 32767));
		send_command(make_read(32767, -32768));
		send_command(make_cmd(CMD_NOP, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom, COLOR_W'($urandom)));
	endtask

	task automatic test_depth_compare();
		send_command(make_cmd(CMD_DRAW, 0, 3, 0, 0, 3, 4, 32'h0100_0000, 32'h0200_0000,
			32'h0300_0000, 32'h0400_0000, 24'h123456));
		send_command(make_read(2, 1));
		// A farther surface over the same area must leave the buffers alone.
		send_command(make_cmd(CMD_DRAW, 0, 3, 0, 0, 3, 4, 32'h0000_0001, 32'h0000_0001,
			32'h0000_0001, 32'h0000_0001, 24'hABCDEF));
		send_command(make_read(2, 1));
		send_command(make_cmd(CMD_DRAW, 1, 5, 1, 1, 5, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF));
		send_command(make_read(2, 1));
		send_command(make_read(0, 0));
	endtask

	task automatic test_special_cases();
		send_command(make_cmd(CMD_DRAW, 10, 20, 20, 10, 20, 10, 1, 2, 3, 4, 24'h00FF00));
		send_command(make_cmd(CMD_DRAW, 10, 20, -5, 10, 20, 0, 5, 5, 5, 5, 24'h0000FF));
		send_command(make_cmd(CMD_DRAW, 10, 20, -8, 10, 20, -1, 5, 5, 5, 5, 24'h0000FF));
		send_command(make_cmd(CMD_DRAW, 10, 20, 256, 10, 20, 300, 5, 5, 5, 5, 24'h0000FF));
		send_command(make_cmd(CMD_DRAW, 240, 300, 250, 230, 290, 300, 32'h0500_0000,
			32'h0600_0000, 32'h0700_0000, 32'h0800_0000, 24'hFF0000));
		send_command(make_read(255, 255));
		send_command(make_cmd(CMD_DRAW, 50, 40, 100, 60, 45, 104, 9, 9, 9, 9, 24'h777777));
		send_command(make_cmd(CMD_DRAW, -100, 20, 110, -90, 30, 114, 32'h1000_0000,
			32'h0000_0100, 32'h00FF_0000, 32'h2000_0000, 24'h0F0F0F));
		send_command(make_read(0, 111));
		// Extreme rows and columns cover the whole screen in one pass.
		send_command(make_cmd(CMD_DRAW, -32768, 32767, -32768, -32768, 32767, 32767,
			$urandom, $urandom, $urandom, $urandom, COLOR_W'($urandom)));
		send_command(make_read(128, 128));
	endtask

	task automatic test_random_traffic(int count);
		int n, r;
		for (n = 0; n < count; n++) begin
			quiet_phase = ((n / 15) % 4 == 3);
			r = rnd(0, 99);
			if (r < 50)
				send_command(random_draw());
			else if (r < 88)
				send_command(make_read(rnd(-4, 259), rnd(-4, 270)));
			else if (r < 94)
				send_command(make_read($urandom, $urandom));
			else
				send_command(make_cmd(CMD_NOP, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					COLOR_W'($urandom)));
		end
		quiet_phase = 1'b0;
	endtask

	task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
		$display("mismatch at %0t: %s expected %0h got %0h", $realtime, field, want, got);
		error_count++;
	endtask

	always @(posedge clk) begin
		pixel_result_t want;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction", 0, 1);
			end else begin
				want = pending_results.pop_front();
				if (drawn !== want.drawn)
					report_mismatch("drawn", 32'(want.drawn), 32'(drawn));
				if (pixel_color !== want.color)
					report_mismatch("pixel_color", 32'(want.color), 32'(pixel_color));
				if (pixel_depth !== want.depth)
					report_mismatch("pixel_depth", want.depth, pixel_depth);
			end
		end
	end

	// Output back-pressure: mostly short stalls, now and then a long one.
	always @(posedge clk or negedge arst_n) begin
		int r;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			r = rnd(0, 99);
			out_stall <= 1'b0;
			if (!quiet_phase && r < 30)
				stall_left <= (r < 27) ? rnd(1, 3) : rnd(10, 40);
		end
	end

	initial begin
		#100_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_NOP;
		{top_left_x, top_right_x, top_row, bottom_left_x, bottom_right_x, bottom_row} = '0;
		{top_left_w, top_right_w, bottom_left_w, bottom_right_w} = '0;
		fill_color = '0;
		cfg_valid = 1'b0;
		background_color = '0;
		bg_shadow = '0;
		error_count = 0;
		quiet_phase = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_clear_and_read();
		test_depth_compare();
		test_special_cases();

		write_background(24'hFFFFFF);
		send_command(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		test_random_traffic(60);

		write_background(COLOR_W'($urandom));
		send_command(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		test_random_traffic(55);

		wait_drained();
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
